FILE: sv/asel_pkg.sv
`default_nettype none
package asel_pkg;

  localparam int unsigned MAX_PICKS = 16;
  localparam int unsigned STEP_W    = 3;

  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    logic [7:0]  activity_label;
    logic [15:0] start_time;
    logic [15:0] finish_time;
    logic        is_final;
  } req_t;

  typedef struct packed {
    logic [7:0]  picked_label;
    logic [15:0] picked_start;
    logic [15:0] picked_finish;
    logic [5:0]  pick_ordinal;
    logic        run_end;
    logic        overflow;
  } res_t;

  typedef enum logic [2:0] {
    UOP_LOAD,
    UOP_SCAN_FIRST,
    UOP_TAKE,
    UOP_SCAN_NEXT,
    UOP_EMIT
  } uop_e;

  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_FINAL_REQ,
    COND_SCAN_DONE,
    COND_FOUND
  } cond_e;

  typedef struct packed {
    uop_e  op;
    cond_e cond;
    step_t jump;
    step_t nxt;
  } uword_t;

  localparam step_t STEP_IDLE  = 3'd0;
  localparam step_t STEP_SMIN  = 3'd1;
  localparam step_t STEP_TAKE  = 3'd2;
  localparam step_t STEP_SNEXT = 3'd3;
  localparam step_t STEP_EMIT  = 3'd4;

  // control store: jump when cond holds, else nxt
  function automatic uword_t ucode(input step_t s);
    uword_t w;
    case (s)
      STEP_IDLE:  w = '{UOP_LOAD,       COND_FINAL_REQ, STEP_SMIN,  STEP_IDLE};
      STEP_SMIN:  w = '{UOP_SCAN_FIRST, COND_SCAN_DONE, STEP_TAKE,  STEP_SMIN};
      STEP_TAKE:  w = '{UOP_TAKE,       COND_ALWAYS,    STEP_SNEXT, STEP_SNEXT};
      STEP_SNEXT: w = '{UOP_SCAN_NEXT,  COND_SCAN_DONE, STEP_EMIT,  STEP_SNEXT};
      STEP_EMIT:  w = '{UOP_EMIT,       COND_FOUND,     STEP_SNEXT, STEP_IDLE};
      default:    w = '{UOP_LOAD,       COND_ALWAYS,    STEP_IDLE,  STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

FILE: sv/asel_ram.sv
`default_nettype none
module asel_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

FILE: sv/activity_selection_by_finish_unit.sv
// Channel   Signals                        Handshake
// request   start_i, req_i (req_t)         taken when start_i && !busy_o
// result    res_strobe_o, res_o (res_t)    one-cycle strobe, no backpressure
//
// Loading stores one request per cycle while busy_o is low. The request marked final
// starts selection: a minimum scan of the RAM with registered read, a take step,
// then per pick a scan for a compatible activity with the earliest finish and an emit.
// Async active-low reset clears the sequencer, counters and strobe.
// busy_o is high from the edge after the final request until the last strobe.
`default_nettype none
module activity_selection_by_finish_unit #(
  parameter int unsigned MAX_ACTIVITIES = 16,
  parameter int unsigned TIME_BITS      = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire asel_pkg::req_t req_i,
  output logic                busy_o,
  output logic                res_strobe_o,
  output asel_pkg::res_t      res_o
);
  import asel_pkg::*;

  localparam int unsigned SW     = (TIME_BITS < 16) ? TIME_BITS : 16;
  localparam int unsigned AW     = $clog2(MAX_ACTIVITIES);
  localparam int unsigned CW     = $clog2(MAX_ACTIVITIES + 1);
  localparam int unsigned EW     = 8 + 2 * SW;
  localparam int unsigned PICK_W = $clog2(MAX_PICKS + 1);

  typedef struct packed {
    logic [7:0]    label;
    logic [SW-1:0] st;
    logic [SW-1:0] fin;
  } ent_t;

  step_t             step_q, step_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              ovf_q, ovf_d;
  logic [CW-1:0]     rd_idx_q, rd_idx_d;
  logic              rd_vld_q, rd_vld_d;
  logic              found_q, found_d;
  logic [PICK_W-1:0] picks_q, picks_d;
  logic              strobe_q, strobe_d;
  ent_t              best_q, best_d;
  ent_t              cur_q, cur_d;
  res_t              res_q, res_d;

  uword_t            uw;
  logic              accept;
  logic              scan_done;
  logic              issue;
  logic              cap;
  logic              cond_ok;
  logic              we;
  ent_t              wr_ent;
  logic [EW-1:0]     rd_data;
  ent_t              rd_ent;

  assign uw        = ucode(step_q);
  assign busy_o    = (step_q != STEP_IDLE);
  assign accept    = start_i && !busy_o;
  assign issue     = (rd_idx_q < cnt_q);
  assign scan_done = !issue && !rd_vld_q;
  assign cap       = (picks_q >= PICK_W'(MAX_PICKS - 1));
  assign rd_ent    = ent_t'(rd_data);

  assign wr_ent.label = req_i.activity_label;
  assign wr_ent.st    = req_i.start_time[SW-1:0];
  assign wr_ent.fin   = req_i.finish_time[SW-1:0];
  assign we           = accept && (cnt_q < CW'(MAX_ACTIVITIES));

  asel_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_ACTIVITIES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(cnt_q[AW-1:0]),
    .wdata_i(EW'(wr_ent)),
    .raddr_i(rd_idx_q[AW-1:0]),
    .rdata_o(rd_data)
  );

  // sequencer: next step
  always_comb begin
    case (uw.cond)
      COND_ALWAYS:    cond_ok = 1'b1;
      COND_FINAL_REQ: cond_ok = accept && req_i.is_final;
      COND_SCAN_DONE: cond_ok = scan_done;
      COND_FOUND:     cond_ok = found_q;
      default:        cond_ok = 1'b0;
    endcase
    step_d = cond_ok ? uw.jump : uw.nxt;
  end

  // datapath controls
  always_comb begin
    cnt_d    = cnt_q;
    ovf_d    = ovf_q;
    rd_idx_d = rd_idx_q;
    rd_vld_d = 1'b0;
    found_d  = found_q;
    picks_d  = picks_q;
    strobe_d = 1'b0;
    best_d   = best_q;
    cur_d    = cur_q;
    res_d    = res_q;
    case (uw.op)
      UOP_LOAD: begin
        rd_idx_d = '0;
        found_d  = 1'b0;
        picks_d  = '0;
        if (accept) begin
          if (we) begin
            cnt_d = cnt_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
      end
      UOP_SCAN_FIRST, UOP_SCAN_NEXT: begin
        rd_vld_d = issue;
        if (issue) begin
          rd_idx_d = rd_idx_q + CW'(1);
        end else if (scan_done) begin
          rd_idx_d = '0;
        end
        if (rd_vld_q) begin
          if (uw.op == UOP_SCAN_FIRST) begin
            // lowest index wins ties
            if (!found_q || (rd_ent.fin < best_q.fin)) begin
              best_d  = rd_ent;
              found_d = 1'b1;
            end
          end else if (!cap && (rd_ent.st > cur_q.fin)) begin
            // highest index wins ties
            if (!found_q || (rd_ent.fin <= best_q.fin)) begin
              best_d  = rd_ent;
              found_d = 1'b1;
            end
          end
        end
      end
      UOP_TAKE: begin
        cur_d   = best_q;
        found_d = 1'b0;
      end
      UOP_EMIT: begin
        strobe_d            = 1'b1;
        res_d.picked_label  = cur_q.label;
        res_d.picked_start  = 16'(cur_q.st);
        res_d.picked_finish = 16'(cur_q.fin);
        res_d.pick_ordinal  = 6'(picks_q);
        res_d.run_end       = !found_q;
        res_d.overflow      = ovf_q;
        cur_d               = best_q;
        found_d             = 1'b0;
        picks_d             = picks_q + PICK_W'(1);
        if (!found_q) begin
          cnt_d   = '0;
          ovf_d   = 1'b0;
          picks_d = '0;
        end
      end
      default: begin
        rd_vld_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= STEP_IDLE;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      rd_idx_q <= '0;
      rd_vld_q <= 1'b0;
      found_q  <= 1'b0;
      picks_q  <= '0;
      strobe_q <= 1'b0;
    end else begin
      step_q   <= step_d;
      cnt_q    <= cnt_d;
      ovf_q    <= ovf_d;
      rd_idx_q <= rd_idx_d;
      rd_vld_q <= rd_vld_d;
      found_q  <= found_d;
      picks_q  <= picks_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    cur_q  <= cur_d;
    res_q  <= res_d;
  end

  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

endmodule
`default_nettype wire

FILE: tb/activity_selection_by_finish_unit_tb.sv
`default_nettype none
module activity_selection_by_finish_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import asel_pkg::*;

  localparam int unsigned CAPACITY     = 16;
  localparam int unsigned NUM_REQUESTS = 460;

  class pick_scoreboard;
    logic [7:0]  label_q  [CAPACITY];
    logic [15:0] start_q  [CAPACITY];
    logic [15:0] finish_q [CAPACITY];
    int unsigned held;
    bit          dropped;
    res_t        expected_picks[$];
    int unsigned failures;

    function void select_picks();
      int unsigned cur;
      int unsigned cand;
      int unsigned picks;
      bit          found;
      res_t        p;
      cur = 0;
      for (int unsigned i = 1; i < held; i++)
        if (finish_q[i] < finish_q[cur]) cur = i;
      picks = 0;
      do begin
        found = 1'b0;
        cand  = 0;
        // later picks: start strictly after last finish, ties go to the higher index
        if (picks + 1 < MAX_PICKS) begin
          for (int unsigned i = 0; i < held; i++) begin
            if (start_q[i] > finish_q[cur] && (!found || finish_q[i] <= finish_q[cand])) begin
              cand  = i;
              found = 1'b1;
            end
          end
        end
        p.picked_label  = label_q[cur];
        p.picked_start  = start_q[cur];
        p.picked_finish = finish_q[cur];
        p.pick_ordinal  = 6'(picks);
        p.run_end       = ~found;
        p.overflow      = dropped;
        expected_picks.push_back(p);
        picks++;
        cur = cand;
      end while (found);
    endfunction

    function void note_request(req_t r);
      if (held < CAPACITY) begin
        label_q[held]  = r.activity_label;
        start_q[held]  = r.start_time;
        finish_q[held] = r.finish_time;
        held++;
      end else begin
        dropped = 1'b1;
      end
      if (r.is_final) begin
        if (held != 0) select_picks();
        held    = 0;
        dropped = 1'b0;
      end
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_pick(res_t got);
      res_t want;
      if (expected_picks.size() == 0) begin
        $error("pick with none pending: %p", got);
        failures++;
        return;
      end
      want = expected_picks.pop_front();
      check_field("picked_label", 16'(want.picked_label), 16'(got.picked_label));
      check_field("picked_start", want.picked_start, got.picked_start);
      check_field("picked_finish", want.picked_finish, got.picked_finish);
      check_field("pick_ordinal", 16'(want.pick_ordinal), 16'(got.pick_ordinal));
      check_field("run_end", 16'(want.run_end), 16'(got.run_end));
      check_field("overflow", 16'(want.overflow), 16'(got.overflow));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start_i;
  req_t req_i;
  logic busy_o;
  logic res_strobe_o;
  res_t res_o;
  bit   quiet;

  pick_scoreboard sb = new();

  activity_selection_by_finish_unit #(
    .MAX_ACTIVITIES(CAPACITY),
    .TIME_BITS     (16)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .busy_o      (busy_o),
    .res_strobe_o(res_strobe_o),
    .res_o       (res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_strobe_o) sb.check_pick(res_o);
  end

  function automatic req_t random_activity(bit last);
    req_t r;
    int   s;
    int   f;
    case ($urandom_range(9))
      0: begin
        s = $urandom_range(65535);
        f = $urandom_range(65535);
      end
      1: begin
        s = 65535 - $urandom_range(400);
        f = s + $urandom_range(60);
        if (f > 65535) f = 65535;
      end
      2: begin
        // start after finish
        f = $urandom_range(400);
        s = f + $urandom_range(1, 30);
      end
      default: begin
        s = $urandom_range(400);
        f = s + $urandom_range(60);
      end
    endcase
    r.activity_label = 8'($urandom);
    r.start_time     = 16'(s);
    r.finish_time    = 16'(f);
    r.is_final       = last;
    return r;
  endfunction

  task automatic idle_cycles();
    while (!quiet && $urandom_range(99) < 23) begin
      start_i <= 1'b0;
      req_i   <= random_activity(1'($urandom_range(1)));
      @(posedge clk_i);
    end
  endtask

  task automatic send_request(input req_t r);
    idle_cycles();
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o);
    sb.note_request(r);
  endtask

  task automatic send_activity(input logic [7:0] lbl, input logic [15:0] s,
                               input logic [15:0] f, input bit last);
    req_t r;
    r.activity_label = lbl;
    r.start_time     = s;
    r.finish_time    = f;
    r.is_final       = last;
    send_request(r);
  endtask

  initial begin
    int unsigned sent;
    int unsigned set_size;
    rst_ni  = 1'b0;
    start_i = 1'b0;
    req_i   = '0;
    quiet   = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_activity(8'h00, 16'h0000, 16'h0000, 1'b1);
    send_activity(8'hFF, 16'hFFFF, 16'hFFFF, 1'b1);
    // ties on the first pick and on a later pick
    send_activity(8'h41, 16'd0, 16'd5, 1'b0);
    send_activity(8'h42, 16'd1, 16'd5, 1'b0);
    send_activity(8'h43, 16'd6, 16'd9, 1'b0);
    send_activity(8'h44, 16'd7, 16'd9, 1'b1);
    // reversed interval picks itself until the cap
    send_activity(8'h4D, 16'd10, 16'd5, 1'b1);
    // one past capacity, final request dropped
    for (int unsigned i = 0; i <= CAPACITY; i++)
      send_activity(8'(i + 8'h60), 16'(100 * i), 16'(100 * i + 50), i == CAPACITY);

    sent = 0;
    while (sent < NUM_REQUESTS) begin
      set_size = ($urandom_range(99) < 8) ? $urandom_range(CAPACITY + 1, CAPACITY + 4)
                                          : $urandom_range(1, CAPACITY);
      for (int unsigned k = 0; k < set_size; k++) begin
        quiet = (sent >= 150 && sent < 260);
        send_request(random_activity(k == set_size - 1));
        sent++;
      end
    end
    start_i <= 1'b0;

    while (sb.expected_picks.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (sb.failures == 0) begin
      $display("activity_selection_by_finish_unit regression: pass");
    end else begin
      $display("activity_selection_by_finish_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("activity_selection_by_finish_unit regression: fail");
    $finish;
  end

endmodule
`default_nettype wire
